FILE: rtl/assert_macros.svh
// Assertion macros used by the table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KSEC_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define KSEC_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");

`endif

FILE: rtl/ksec_pkg.sv
// Types and constants of the keyed secret table.
`timescale 1ns / 1ps

package ksec_pkg;

   localparam int SECRET_BITS = 256;

   // Operation codes
   localparam logic [1:0] OP_UPSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] peer_id;
      logic [63:0] secret_w0;
      logic [63:0] secret_w1;
      logic [63:0] secret_w2;
      logic [63:0] secret_w3;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [63:0] found_w0;
      logic [63:0] found_w1;
      logic [63:0] found_w2;
      logic [63:0] found_w3;
      logic [4:0]  occupied_count;
   } rsp_type;

   // Scan token handed from cell to cell
   typedef struct packed {
      logic                   active;
      logic                   hit;
      logic                   free_seen;
      logic [SECRET_BITS-1:0] found;
   } link_type;

   // Outcome broadcast to all cells when the token leaves the chain
   typedef struct packed {
      logic fill_tent;
      logic write_hit;
      logic wipe_hit;
      logic wipe_all;
   } commit_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_SCAN
   } state_type;

endpackage

FILE: rtl/ksec_cell.sv
// One table slot: holds key and secret, compares and forwards the scan token.
`timescale 1ns / 1ps

module ksec_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  ksec_pkg::link_type              link_in,
   input  logic [31:0]                     key,
   input  logic [ksec_pkg::SECRET_BITS-1:0] secret,
   input  ksec_pkg::commit_type            commit,
   output ksec_pkg::link_type              link_out,
   output logic                            hit_flag
);

   logic                             valid_ff;
   logic [31:0]                      peer_ff;
   logic [ksec_pkg::SECRET_BITS-1:0] secret_ff;
   logic                             hit_ff;
   logic                             tent_ff;
   ksec_pkg::link_type               link_ff;
   ksec_pkg::link_type               link_in_next;
   logic                             my_hit;
   logic                             do_write;

   assign my_hit = valid_ff && (peer_ff == key);

   // Token update: accumulate hit, free slot and found secret
   always_comb begin
      link_in_next.active    = link_in.active;
      link_in_next.hit       = link_in.hit | my_hit;
      link_in_next.free_seen = link_in.free_seen | ~valid_ff;
      link_in_next.found     = my_hit ? secret_ff : link_in.found;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= '0;
      end else begin
         link_ff <= link_in_next;
      end
   end

   // Remember this slot's role while the token passes
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff  <= 1'b0;
         tent_ff <= 1'b0;
      end else if (link_in.active) begin
         hit_ff  <= my_hit;
         tent_ff <= ~valid_ff & ~link_in.free_seen;
      end
   end

   assign do_write = (commit.fill_tent && tent_ff) || (commit.write_hit && hit_ff);

   // Occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (commit.wipe_all || (commit.wipe_hit && hit_ff)) begin
         valid_ff <= 1'b0;
      end else if (do_write) begin
         valid_ff <= 1'b1;
      end
   end

   // Slot payload
   always_ff @(posedge clock) begin
      if (do_write) begin
         peer_ff   <= key;
         secret_ff <= secret;
      end
   end

   assign link_out = link_ff;
   assign hit_flag = hit_ff;

endmodule

FILE: rtl/keyed_secret_table.sv
// Top level of the keyed secret table: command control and the row of cells.
//
//   channel   ports                      direction   transfer
//   request   start, busy, req_data      in          start high, busy low
//   response  rsp_strobe, rsp_data       out         strobe high, one cycle
//   config    csr_we, csr_wdata          in          csr_we high
//
// An accepted item passes the launch state, then the scan token walks the cells
// one slot per cycle and commits on exit; the response is registered at that commit.
// busy falls with the response strobe, and a start in that cycle is accepted, so a
// new item is taken only once the previous one has responded.
// Synchronous reset empties the table and sets broadcast_id to all ones.
// The response cannot be stalled; it is held in a register until the next response.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module keyed_secret_table #(
   parameter int ENTRIES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ksec_pkg::req_type req_data,
   output logic              rsp_strobe,
   output ksec_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [31:0]       csr_wdata
);

   localparam int CW = $clog2(ENTRIES + 1);

   ksec_pkg::state_type state_ff, state_in;
   logic [31:0]                      bcast_ff;
   logic [1:0]                       op_ff;
   logic [31:0]                      key_ff;
   logic [ksec_pkg::SECRET_BITS-1:0] secret_ff;
   logic                             key_ok_ff;
   logic                             nz_ff;
   logic [CW-1:0]                    total_ff, total_in;
   logic [CW+4:0]                    total_ext;
   logic                             rsp_strobe_ff;
   ksec_pkg::rsp_type                rsp_ff, rsp_in;
   logic                             accept;
   logic                             launch;
   ksec_pkg::link_type               head;
   ksec_pkg::link_type               link_vec [ENTRIES];
   ksec_pkg::link_type               tail;
   logic [ENTRIES-1:0]               hit_vec;
   ksec_pkg::commit_type             commit;
   logic                             upsert_go;
   logic                             lookup_hit;

   assign accept = start && !busy;

   // Broadcast id register
   always_ff @(posedge clock) begin
      if (reset) begin
         bcast_ff <= '1;
      end else if (csr_we) begin
         bcast_ff <= csr_wdata;
      end
   end

   // Command capture
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_data.op;
         key_ff    <= req_data.peer_id;
         secret_ff <= {req_data.secret_w3, req_data.secret_w2,
                       req_data.secret_w1, req_data.secret_w0};
         key_ok_ff <= (req_data.peer_id != 32'd0) && (req_data.peer_id != bcast_ff);
         nz_ff     <= |{req_data.secret_w3, req_data.secret_w2,
                        req_data.secret_w1, req_data.secret_w0};
      end
   end

   // Control FSM: next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ksec_pkg::ST_IDLE:   if (start) state_in = ksec_pkg::ST_LAUNCH;
         ksec_pkg::ST_LAUNCH: state_in = ksec_pkg::ST_SCAN;
         ksec_pkg::ST_SCAN:   if (tail.active) state_in = ksec_pkg::ST_IDLE;
         default:             state_in = ksec_pkg::ST_IDLE;
      endcase
   end

   // Control FSM: outputs
   always_comb begin
      busy   = 1'b1;
      launch = 1'b0;
      case (state_ff)
         ksec_pkg::ST_IDLE:   busy = 1'b0;
         ksec_pkg::ST_LAUNCH: launch = 1'b1;
         ksec_pkg::ST_SCAN:   launch = 1'b0;
         default:             busy = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ksec_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Token entering the first cell
   always_comb begin
      head           = '0;
      head.active    = launch;
   end

   // Row of cells
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      ksec_pkg::link_type link_left;
      if (i == 0) begin : g_first
         assign link_left = head;
      end else begin : g_next
         assign link_left = link_vec[i-1];
      end
      ksec_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .link_in  (link_left),
         .key      (key_ff),
         .secret   (secret_ff),
         .commit   (commit),
         .link_out (link_vec[i]),
         .hit_flag (hit_vec[i])
      );
   end

   assign tail = link_vec[ENTRIES-1];

   // Outcome of the scan
   assign upsert_go  = (op_ff == ksec_pkg::OP_UPSERT) && key_ok_ff && nz_ff;
   assign lookup_hit = tail.active && (op_ff == ksec_pkg::OP_LOOKUP) && key_ok_ff && tail.hit;

   always_comb begin
      commit.write_hit = tail.active && upsert_go && tail.hit;
      commit.fill_tent = tail.active && upsert_go && !tail.hit && tail.free_seen;
      commit.wipe_hit  = tail.active && (op_ff == ksec_pkg::OP_REMOVE) && key_ok_ff
                         && tail.hit;
      commit.wipe_all  = tail.active && (op_ff == ksec_pkg::OP_CLEAR);
   end

   // Occupied count
   always_comb begin
      total_in = total_ff;
      if (commit.wipe_all) begin
         total_in = '0;
      end else if (commit.fill_tent) begin
         total_in = total_ff + CW'(1);
      end else if (commit.wipe_hit && (total_ff != '0)) begin
         total_in = total_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

   assign total_ext = {5'd0, total_in};

   // Response
   always_comb begin
      rsp_in.ok = commit.write_hit | commit.fill_tent | commit.wipe_hit
                  | commit.wipe_all | lookup_hit;
      rsp_in.found_w0       = lookup_hit ? tail.found[63:0]    : 64'd0;
      rsp_in.found_w1       = lookup_hit ? tail.found[127:64]  : 64'd0;
      rsp_in.found_w2       = lookup_hit ? tail.found[191:128] : 64'd0;
      rsp_in.found_w3       = lookup_hit ? tail.found[255:192] : 64'd0;
      rsp_in.occupied_count = total_ext[4:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= tail.active;
      end
   end

   always_ff @(posedge clock) begin
      if (tail.active) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Checks
   `KSEC_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy)
   `KSEC_ASSERT_NEXT(a_done_strobe, clock, reset, tail.active, rsp_strobe && !busy)
   `KSEC_ASSERT_IMPLY(a_unique_key, clock, reset, tail.active, $onehot0(hit_vec))
   `KSEC_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, total_ff <= CW'(ENTRIES))

endmodule
